### rtl/rsfp_pkg.sv
package rsfp_pkg;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    // Word index of each register (byte address bits [2:2])
    localparam logic [0:0] REG_RADIX_MODE = 1'd0;

    // Radix codes; the unused code falls back to hexadecimal
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_RESET = RADIX_HEX;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_POINT = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [3:0] HEX_TEN  = 4'd10;

    localparam int unsigned VALUE_W = 64;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } result_item_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } digit_t;

    // Digit value of a character in the selected radix
    function automatic digit_t digit_of(input logic [1:0] mode, input logic [7:0] c);
        digit_t d;
        d.valid = 1'b0;
        d.val   = 4'd0;
        unique case (mode)
            RADIX_BIN:
            begin
                d.valid = (c == CH_ZERO) || (c == CH_ONE);
                d.val   = c[3:0];
            end
            RADIX_OCT:
            begin
                d.valid = (c >= CH_ZERO) && (c <= CH_SEVEN);
                d.val   = c[3:0];
            end
            default:
            begin
                if ((c >= CH_ZERO) && (c <= CH_NINE))
                begin
                    d.valid = 1'b1;
                    d.val   = c[3:0];
                end
                else if ((c >= CH_UP_A) && (c <= CH_UP_F))
                begin
                    d.valid = 1'b1;
                    d.val   = HEX_TEN + 4'(c - CH_UP_A);
                end
                else if ((c >= CH_LO_A) && (c <= CH_LO_F))
                begin
                    d.valid = 1'b1;
                    d.val   = HEX_TEN + 4'(c - CH_LO_A);
                end
            end
        endcase
        return d;
    endfunction

    // Bits carried by one digit
    function automatic logic [2:0] digit_bits(input logic [1:0] mode);
        logic [2:0] k;
        unique case (mode)
            RADIX_BIN: k = 3'd1;
            RADIX_OCT: k = 3'd3;
            default:   k = 3'd4;
        endcase
        return k;
    endfunction

endpackage

### rtl/rsfp_cfg.sv
module rsfp_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsfp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rsfp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rsfp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [1:0]                         radix_mode
);

    logic [1:0] radix_reg;
    logic [1:0] radix_next;
    logic       sel_radix;

    assign sel_radix = (paddr[2:2] == rsfp_pkg::REG_RADIX_MODE);
    assign pready    = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && sel_radix)
        begin
            radix_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rsfp_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign prdata     = sel_radix ? rsfp_pkg::APB_DATA_W'(radix_reg) : '0;
    assign radix_mode = radix_reg;

endmodule

### rtl/rsfp_core.sv
module rsfp_core #(
    parameter int INT_BITS  = 32,
    parameter int FRAC_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  rsfp_pkg::char_item_t     item,
    input  logic [1:0]               radix_mode,
    output rsfp_pkg::result_item_t   result
);

    localparam int FB    = (FRAC_BITS > 62) ? 62 : FRAC_BITS;
    localparam int IB    = (INT_BITS + FB > 64) ? (64 - FB) : ((INT_BITS < 2) ? 2 : INT_BITS);
    localparam int IPW   = IB - 1;
    localparam int MAG_W = IPW + FB;
    localparam int FBL_W = $clog2(FB + 1);

    rsfp_pkg::phase_t   phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [FBL_W-1:0]   fbl_reg, fbl_next;
    logic               ovf_reg, ovf_next;

    rsfp_pkg::phase_t   ph;
    logic               neg_w;
    logic [MAG_W-1:0]   mag_w;
    logic [FBL_W-1:0]   fbl_w;
    logic               ovf_w;
    logic               skip;
    rsfp_pkg::digit_t   dig;
    logic [2:0]         k;
    logic [IPW+3:0]     grown;
    logic [FB+3:0]      placed;
    logic [63:0]        mag64;

    assign dig = rsfp_pkg::digit_of(radix_mode, item.char_code);
    assign k   = rsfp_pkg::digit_bits(radix_mode);

    // Integer digit: shift the integer part up by one digit and insert it
    assign grown  = ({4'd0, mag_reg[FB +: IPW]} << k) | (IPW+4)'(dig.val);
    // Fraction digit: top of the digit lands just below the bits already used
    assign placed = ((FB+4)'(dig.val) << fbl_reg) >> k;

    always_comb
    begin
        ph    = phase_reg;
        neg_w = neg_reg;
        mag_w = mag_reg;
        fbl_w = fbl_reg;
        ovf_w = ovf_reg;
        skip  = 1'b0;
        if (phase_reg != rsfp_pkg::PH_STOP)
        begin
            if (phase_reg == rsfp_pkg::PH_START)
            begin
                ph = rsfp_pkg::PH_INT;
                if (item.char_code == rsfp_pkg::CH_MINUS)
                begin
                    neg_w = 1'b1;
                    skip  = 1'b1;
                end
            end
            if (!skip)
            begin
                if (ph == rsfp_pkg::PH_INT)
                begin
                    if (dig.valid)
                    begin
                        if (!ovf_reg)
                        begin
                            if (|grown[IPW+3:IPW])
                            begin
                                // saturate: largest integer, all fraction bits set
                                ovf_w = 1'b1;
                                mag_w = '1;
                            end
                            else
                            begin
                                mag_w = {grown[IPW-1:0], mag_reg[FB-1:0]};
                            end
                        end
                    end
                    else if (item.char_code == rsfp_pkg::CH_POINT)
                    begin
                        ph = rsfp_pkg::PH_FRAC;
                    end
                    else
                    begin
                        ph = rsfp_pkg::PH_STOP;
                    end
                end
                else
                begin
                    if (dig.valid)
                    begin
                        if (!ovf_reg)
                        begin
                            mag_w = mag_reg | MAG_W'(placed[FB-1:0]);
                            fbl_w = (fbl_reg >= FBL_W'(k)) ? (fbl_reg - FBL_W'(k)) : '0;
                        end
                    end
                    else
                    begin
                        ph = rsfp_pkg::PH_STOP;
                    end
                end
            end
        end
    end

    assign mag64           = 64'(mag_w);
    assign result.value    = neg_w ? (64'd0 - mag64) : mag64;
    assign result.overflow = ovf_w;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        fbl_next   = fbl_reg;
        ovf_next   = ovf_reg;
        if (go)
        begin
            if (item.last_char)
            begin
                phase_next = rsfp_pkg::PH_START;
                neg_next   = 1'b0;
                mag_next   = '0;
                fbl_next   = FBL_W'(FB);
                ovf_next   = 1'b0;
            end
            else
            begin
                phase_next = ph;
                neg_next   = neg_w;
                mag_next   = mag_w;
                fbl_next   = fbl_w;
                ovf_next   = ovf_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsfp_pkg::PH_START;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            fbl_reg   <= FBL_W'(FB);
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            fbl_reg   <= fbl_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rsfp_pkg::PH_STOP) && !(go && item.last_char)
        |=> (phase_reg == rsfp_pkg::PH_STOP))
        else $error("parser left the stopped phase before the end of the string");

    a_sat_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(go && item.last_char) |=> ovf_reg && (mag_reg == {MAG_W{1'b1}}))
        else $error("saturated magnitude changed before the end of the string");

    a_frac_budget: assert property (@(posedge clk) disable iff (!rst_n)
        fbl_reg <= FBL_W'(FB))
        else $error("fraction bit count beyond the fraction width");

endmodule

### rtl/radix_string_to_fixed_point.sv
// Channel   | Direction | Payload                          | Handshake
// ----------+-----------+----------------------------------+--------------------------
// char      | in        | char_code[7:0], last_char        | char_valid / char_stall
// result    | out       | value[63:0] signed, overflow     | result_valid / result_stall
// cfg (APB) | in/out    | radix_mode at byte address 0     | psel / penable / pready
//
// One character per cycle while char_stall is low: a transfer lands in the input
// register; the parse logic then updates the string state from it and, on the last
// character, loads the result register. A character reaches result_valid through the
// input register and then the result register. Reset clears the string state, empties
// both registers and sets hex radix. A stalled result holds the last character in the
// input register, and no further character enters meanwhile; other characters are not
// held by a stalled result, since they produce no result.
module radix_string_to_fixed_point #(
    parameter int INT_BITS  = 32,
    parameter int FRAC_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // character stream
    input  logic                                char_valid,
    output logic                                char_stall,
    input  rsfp_pkg::char_item_t                char_item,
    // results
    output logic                                result_valid,
    input  logic                                result_stall,
    output rsfp_pkg::result_item_t              result_item,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rsfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rsfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int FB    = (FRAC_BITS > 62) ? 62 : FRAC_BITS;
    localparam int IB    = (INT_BITS + FB > 64) ? (64 - FB) : ((INT_BITS < 2) ? 2 : INT_BITS);
    localparam int SAT_W = IB - 1 + FB;
    localparam logic [63:0] SAT_MAG = 64'({SAT_W{1'b1}});

    logic                      in_vld_reg, in_vld_next;
    rsfp_pkg::char_item_t      in_item_reg, in_item_next;
    logic                      out_vld_reg, out_vld_next;
    rsfp_pkg::result_item_t    out_item_reg, out_item_next;
    rsfp_pkg::result_item_t    core_result;
    logic [1:0]                radix_mode;
    logic                      go;
    logic                      char_xfer;

    rsfp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .radix_mode (radix_mode)
    );

    rsfp_core #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item       (in_item_reg),
        .radix_mode (radix_mode),
        .result     (core_result)
    );

    // Parse the held character unless it is the last one and the result slot is
    // still occupied by a stalled result.
    assign go         = in_vld_reg && !(in_item_reg.last_char && out_vld_reg && result_stall);
    assign char_stall = in_vld_reg && !go;
    assign char_xfer  = char_valid && !char_stall;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_item_next = in_item_reg;
        if (char_xfer)
        begin
            in_vld_next  = 1'b1;
            in_item_next = char_item;
        end
        else if (go)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_item_next = out_item_reg;
        if (go && in_item_reg.last_char)
        begin
            out_vld_next  = 1'b1;
            out_item_next = core_result;
        end
        else if (!result_stall)
        begin
            // drop the result once it has been taken
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_vld_reg;
    assign result_item  = out_item_reg;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg ##1 out_vld_reg |-> $past(in_vld_reg && in_item_reg.last_char))
        else $error("result appeared without a last character");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_item_reg.overflow
        |-> (out_item_reg.value == SAT_MAG) || (out_item_reg.value == 64'd0 - SAT_MAG))
        else $error("overflow flagged but value is not saturated");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && result_stall |=> out_vld_reg && $stable(out_item_reg))
        else $error("stalled result was overwritten");

endmodule
